// ----- src/rcsp_pkg.sv -----
// shared widths, types and helper functions of the recovery packet size planner
package rcsp_pkg;

    localparam int FILE_W  = 48;
    localparam int FOOT_W  = 11;
    localparam int BLK_W   = 32;
    localparam int NAME_W  = 12;
    localparam int RED_W   = 8;
    localparam int CRE_W   = 16;
    localparam int TOT_W   = 64;
    localparam int INB_W   = 49;
    localparam int REC_W   = 50;
    localparam int REP_W   = 7;
    localparam int EXT_W   = 54;
    localparam int FPK_W   = 13;
    localparam int COM_W   = 56;
    localparam int PROD_W  = 58;
    localparam int Y_W     = 56;
    localparam int DQ_W    = 64;
    localparam int DIG_W   = 8;
    localparam int DREM_W  = 5;
    localparam int DIV_ST  = FILE_W;
    localparam int DV_ST   = 4;
    localparam int DV_DPS  = DQ_W / (DIG_W * DV_ST);
    localparam int TAIL_W  = 6;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = CRE_W;
    localparam logic [CFG_IDX_W-1:0] CFG_REDUNDANCY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CREATOR    = 1'd1;

    localparam logic [RED_W-1:0]  RED_MAX     = 8'd250;
    localparam logic [BLK_W-1:0]  TAIL_MIN    = 32'd40;
    localparam logic [PROD_W-1:0] CEIL_ADD    = 58'd99;
    localparam logic [12:0]       RECIP_25    = 13'd5243;
    localparam int                RECIP_SH    = 17;
    localparam logic [12:0]       DIVISOR_25  = 13'd25;
    localparam logic [COM_W-1:0]  START_BYTES = 56'd82;
    localparam logic [INB_W:0]    WIDE_LIMIT  = 50'd256;
    localparam logic [EXT_W-1:0]  EXT_HDR     = 54'd56;
    localparam logic [COM_W-1:0]  MATRIX_BYTES = 56'd72;
    localparam logic [FPK_W-1:0]  FILE_HDR    = 13'd91;
    localparam logic [COM_W-1:0]  ROOT_BYTES  = 56'd77;
    localparam logic [BLK_W:0]    RDATA_HDR   = 33'd88;

    typedef struct packed {
        logic [BLK_W-1:0]  blk;
        logic [NAME_W-1:0] name;
        logic [FOOT_W-1:0] foot;
    } t_side;

    typedef struct packed {
        logic [FILE_W-1:0] num;
        logic [FILE_W-1:0] q;
        logic [BLK_W-1:0]  rem;
        logic [FOOT_W-1:0] fnum;
        logic [FOOT_W-1:0] fq;
        logic [FOOT_W-1:0] frem;
        t_side             side;
    } t_dstage;

    typedef struct packed {
        logic [FILE_W-1:0] dq;
        logic [BLK_W-1:0]  dr;
        logic [FOOT_W-1:0] fq;
        logic [FOOT_W-1:0] fr;
        t_side             side;
    } t_divres;

    typedef struct packed {
        logic [INB_W-1:0] inb;
        logic [EXT_W-1:0] ext;
        logic [FPK_W-1:0] fpk;
        logic [BLK_W-1:0] blk;
    } t_mid;

    typedef struct packed {
        logic [DQ_W-1:0]   num;
        logic [DQ_W-1:0]   q;
        logic [DREM_W-1:0] rem;
        t_mid              mid;
    } t_qstage;

    typedef struct packed {
        logic [DIG_W-1:0]  q;
        logic [DREM_W-1:0] rem;
    } t_d25;

    // one base-256 digit of a long division by 25, reciprocal multiply
    function automatic t_d25 div25_digit(input logic [DREM_W-1:0] rem,
                                         input logic [DIG_W-1:0] dig);
        logic [12:0] v;
        logic [25:0] m;
        logic [12:0] back;
        t_d25        res;
        v       = {rem, dig};
        m       = 26'(v) * 26'(RECIP_25);
        res.q   = m[RECIP_SH+DIG_W-1:RECIP_SH];
        back    = v - 13'(res.q) * DIVISOR_25;
        res.rem = back[DREM_W-1:0];
        return res;
    endfunction

    // repeat cap from redundancy
    function automatic logic [REP_W-1:0] rep_cap(input logic [RED_W-1:0] red,
                                                 input logic [REP_W-1:0] p);
        logic [REP_W-1:0] cap;
        case (red) inside
            [8'd0:8'd5]:  cap = 7'd4;
            [8'd6:8'd10]: cap = red[REP_W-1:0] - 7'd1;
            8'd11:        cap = 7'd9;
            8'd12:        cap = 7'd10;
            8'd13:        cap = 7'd11;
            8'd14:        cap = 7'd12;
            8'd15:        cap = 7'd13;
            8'd16:        cap = 7'd13;
            8'd17:        cap = 7'd14;
            8'd18:        cap = 7'd15;
            8'd19:        cap = 7'd15;
            default:      cap = p;
        endcase
        return (p > cap) ? cap : p;
    endfunction

endpackage

// ----- src/rcsp_div.sv -----
// pipelined restoring divider, data and footer lanes by block size
module rcsp_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [rcsp_pkg::FILE_W-1:0] i_data,
    input  rcsp_pkg::t_side         i_side,
    output logic                    o_valid,
    output rcsp_pkg::t_divres       o_res
);

    logic [rcsp_pkg::DIV_ST-1:0] r_vld;
    rcsp_pkg::t_dstage r_st [rcsp_pkg::DIV_ST];
    rcsp_pkg::t_dstage n_st [rcsp_pkg::DIV_ST];
    rcsp_pkg::t_dstage w_cur [rcsp_pkg::DIV_ST];

    always_comb begin
        w_cur[0].num  = i_data;
        w_cur[0].q    = '0;
        w_cur[0].rem  = '0;
        w_cur[0].fnum = i_side.foot;
        w_cur[0].fq   = '0;
        w_cur[0].frem = '0;
        w_cur[0].side = i_side;
        for (int s = 1; s < rcsp_pkg::DIV_ST; s++) begin
            w_cur[s] = r_st[s-1];
        end
    end

    always_comb begin
        logic [rcsp_pkg::BLK_W:0]    rr;
        logic [rcsp_pkg::FOOT_W:0]   frr;
        for (int s = 0; s < rcsp_pkg::DIV_ST; s++) begin
            n_st[s] = w_cur[s];
            // data lane, one quotient bit per stage
            rr = {w_cur[s].rem, w_cur[s].num[rcsp_pkg::FILE_W-1]};
            n_st[s].num = {w_cur[s].num[rcsp_pkg::FILE_W-2:0], 1'b0};
            if (rr >= {1'b0, w_cur[s].side.blk}) begin
                n_st[s].rem = rcsp_pkg::BLK_W'(rr - {1'b0, w_cur[s].side.blk});
                n_st[s].q   = {w_cur[s].q[rcsp_pkg::FILE_W-2:0], 1'b1};
            end else begin
                n_st[s].rem = rr[rcsp_pkg::BLK_W-1:0];
                n_st[s].q   = {w_cur[s].q[rcsp_pkg::FILE_W-2:0], 1'b0};
            end
            // footer lane runs in the first stages only
            frr = {w_cur[s].frem, w_cur[s].fnum[rcsp_pkg::FOOT_W-1]};
            if (s < rcsp_pkg::FOOT_W) begin
                n_st[s].fnum = {w_cur[s].fnum[rcsp_pkg::FOOT_W-2:0], 1'b0};
                if ({{(rcsp_pkg::BLK_W-rcsp_pkg::FOOT_W-1){1'b0}}, frr}
                        >= w_cur[s].side.blk) begin
                    n_st[s].frem = rcsp_pkg::FOOT_W'(
                        frr - w_cur[s].side.blk[rcsp_pkg::FOOT_W:0]);
                    n_st[s].fq   = {w_cur[s].fq[rcsp_pkg::FOOT_W-2:0], 1'b1};
                end else begin
                    n_st[s].frem = frr[rcsp_pkg::FOOT_W-1:0];
                    n_st[s].fq   = {w_cur[s].fq[rcsp_pkg::FOOT_W-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[rcsp_pkg::DIV_ST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid  = r_vld[rcsp_pkg::DIV_ST-1];
    assign o_res.dq = r_st[rcsp_pkg::DIV_ST-1].q;
    assign o_res.dr = r_st[rcsp_pkg::DIV_ST-1].rem;
    assign o_res.fq = r_st[rcsp_pkg::DIV_ST-1].fq;
    assign o_res.fr = r_st[rcsp_pkg::DIV_ST-1].frem;
    assign o_res.side = r_st[rcsp_pkg::DIV_ST-1].side;

endmodule

// ----- src/rcsp_dv100.sv -----
// pipelined long division by 25, two base-256 digits per stage
module rcsp_dv100 (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [rcsp_pkg::Y_W-1:0]   i_y,
    input  rcsp_pkg::t_mid             i_mid,
    output logic                       o_valid,
    output logic [rcsp_pkg::REC_W-1:0] o_q,
    output rcsp_pkg::t_mid             o_mid
);

    logic [rcsp_pkg::DV_ST-1:0] r_vld;
    rcsp_pkg::t_qstage r_st [rcsp_pkg::DV_ST];
    rcsp_pkg::t_qstage n_st [rcsp_pkg::DV_ST];
    rcsp_pkg::t_qstage w_cur [rcsp_pkg::DV_ST];

    always_comb begin
        w_cur[0].num = {{(rcsp_pkg::DQ_W-rcsp_pkg::Y_W){1'b0}}, i_y};
        w_cur[0].q   = '0;
        w_cur[0].rem = '0;
        w_cur[0].mid = i_mid;
        for (int s = 1; s < rcsp_pkg::DV_ST; s++) begin
            w_cur[s] = r_st[s-1];
        end
    end

    always_comb begin
        rcsp_pkg::t_d25 d;
        for (int s = 0; s < rcsp_pkg::DV_ST; s++) begin
            n_st[s] = w_cur[s];
            for (int j = 0; j < rcsp_pkg::DV_DPS; j++) begin
                d = rcsp_pkg::div25_digit(n_st[s].rem,
                        n_st[s].num[rcsp_pkg::DQ_W-1 -: rcsp_pkg::DIG_W]);
                n_st[s].num = {n_st[s].num[rcsp_pkg::DQ_W-rcsp_pkg::DIG_W-1:0],
                               {rcsp_pkg::DIG_W{1'b0}}};
                n_st[s].q   = {n_st[s].q[rcsp_pkg::DQ_W-rcsp_pkg::DIG_W-1:0], d.q};
                n_st[s].rem = d.rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[rcsp_pkg::DV_ST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_valid = r_vld[rcsp_pkg::DV_ST-1];
    assign o_q     = r_st[rcsp_pkg::DV_ST-1].q[rcsp_pkg::REC_W-1:0];
    assign o_mid   = r_st[rcsp_pkg::DV_ST-1].mid;

endmodule

// ----- src/rcsp_plan.sv -----
// block counts, recovery count, packet sums and total, after the divider
module rcsp_plan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  rcsp_pkg::t_divres            i_res,
    input  logic [rcsp_pkg::RED_W-1:0]   i_red,
    input  logic [rcsp_pkg::CRE_W-1:0]   i_creator,
    output logic                         o_valid,
    output logic [rcsp_pkg::TOT_W-1:0]   o_total,
    output logic [rcsp_pkg::INB_W-1:0]   o_inb,
    output logic [rcsp_pkg::REC_W-1:0]   o_rec,
    output logic [rcsp_pkg::REP_W-1:0]   o_rep
);

    // stage 1: tails, input blocks, file packet
    logic                         r_v1;
    logic [rcsp_pkg::INB_W-1:0]   r1_inb, n1_inb;
    logic [rcsp_pkg::FILE_W-1:0]  r1_dq;
    logic [rcsp_pkg::FOOT_W-1:0]  r1_fq;
    logic [rcsp_pkg::FPK_W-1:0]   r1_fpk, n1_fpk;
    logic [rcsp_pkg::BLK_W-1:0]   r1_blk;

    always_comb begin
        logic                        dt40, ft40, share;
        logic [1:0]                  tails;
        logic [rcsp_pkg::TAIL_W-1:0] cd_d, cd_f;
        logic [rcsp_pkg::FOOT_W-1:0] ft_min;
        dt40  = i_res.dr >= rcsp_pkg::TAIL_MIN;
        ft40  = {{(rcsp_pkg::BLK_W-rcsp_pkg::FOOT_W){1'b0}}, i_res.fr} >= rcsp_pkg::TAIL_MIN;
        share = dt40 && (({1'b0, i_res.dr} + {{(rcsp_pkg::BLK_W-rcsp_pkg::FOOT_W+1){1'b0}},
                 i_res.fr}) <= {1'b0, i_res.side.blk});
        tails = {1'b0, dt40} + {1'b0, ft40 && !share};
        n1_inb = {1'b0, i_res.dq}
               + {{(rcsp_pkg::INB_W-rcsp_pkg::FOOT_W){1'b0}}, i_res.fq}
               + {{(rcsp_pkg::INB_W-2){1'b0}}, tails};
        // chunk descriptions: 8, plus 8 for whole blocks, plus tail up to 40
        cd_d = 6'd8 + ((i_res.dq != '0) ? 6'd8 : 6'd0)
             + (dt40 ? 6'd40 : i_res.dr[rcsp_pkg::TAIL_W-1:0]);
        ft_min = ft40 ? 11'd40 : i_res.fr;
        cd_f = 6'd8 + ((i_res.fq != '0) ? 6'd8 : 6'd0) + ft_min[rcsp_pkg::TAIL_W-1:0];
        n1_fpk = rcsp_pkg::FILE_HDR
               + {{(rcsp_pkg::FPK_W-rcsp_pkg::NAME_W){1'b0}}, i_res.side.name}
               + {{(rcsp_pkg::FPK_W-rcsp_pkg::TAIL_W){1'b0}}, cd_d}
               + ((i_res.side.foot != '0)
                  ? {{(rcsp_pkg::FPK_W-rcsp_pkg::TAIL_W-1){1'b0}}, cd_f, 1'b0} : '0);
    end

    // stage 2: redundancy product and external data packet
    logic                         r_v2;
    logic [rcsp_pkg::Y_W-1:0]     r2_y, n2_y;
    rcsp_pkg::t_mid               r2_mid, n2_mid;

    always_comb begin
        logic [rcsp_pkg::PROD_W-1:0] prod;
        logic [rcsp_pkg::EXT_W-1:0]  ext_d, ext_f;
        prod = rcsp_pkg::PROD_W'(r1_inb) * rcsp_pkg::PROD_W'(i_red) + rcsp_pkg::CEIL_ADD;
        // divide by 4 here, by 25 in the following unit
        n2_y = prod[rcsp_pkg::PROD_W-1:2];
        ext_d = rcsp_pkg::EXT_HDR
              + {{(rcsp_pkg::EXT_W-rcsp_pkg::FILE_W-4){1'b0}}, r1_dq, 4'b0}
              + {{(rcsp_pkg::EXT_W-rcsp_pkg::FILE_W-3){1'b0}}, r1_dq, 3'b0};
        ext_f = rcsp_pkg::EXT_HDR
              + {{(rcsp_pkg::EXT_W-rcsp_pkg::FOOT_W-4){1'b0}}, r1_fq, 4'b0}
              + {{(rcsp_pkg::EXT_W-rcsp_pkg::FOOT_W-3){1'b0}}, r1_fq, 3'b0};
        n2_mid.ext = ext_d + ((r1_fq != '0) ? ext_f : '0);
        n2_mid.inb = r1_inb;
        n2_mid.fpk = r1_fpk;
        n2_mid.blk = r1_blk;
    end

    logic                         w_qv;
    logic [rcsp_pkg::REC_W-1:0]   w_q;
    rcsp_pkg::t_mid               w_qmid;

    rcsp_dv100 u_dv100 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_v2),
        .i_y     (r2_y),
        .i_mid   (r2_mid),
        .o_valid (w_qv),
        .o_q     (w_q),
        .o_mid   (w_qmid)
    );

    // stage 3: recovery count, common size, repeat count
    logic                         r_v3;
    logic [rcsp_pkg::REC_W-1:0]   r3_rec, n3_rec;
    logic [rcsp_pkg::COM_W-1:0]   r3_com, n3_com;
    logic [rcsp_pkg::REP_W-1:0]   r3_rep, n3_rep;
    logic [rcsp_pkg::INB_W-1:0]   r3_inb;
    logic [rcsp_pkg::BLK_W-1:0]   r3_blk;

    always_comb begin
        logic [rcsp_pkg::REC_W-1:2] th;
        logic [rcsp_pkg::REP_W-1:0] p;
        logic                       wide;
        n3_rec = (w_q == '0) ? rcsp_pkg::REC_W'(1) : w_q;
        wide = ({1'b0, w_qmid.inb} + n3_rec) > rcsp_pkg::WIDE_LIMIT;
        n3_com = rcsp_pkg::START_BYTES + {{(rcsp_pkg::COM_W-1){1'b0}}, wide}
               + {{(rcsp_pkg::COM_W-rcsp_pkg::EXT_W){1'b0}}, w_qmid.ext}
               + rcsp_pkg::MATRIX_BYTES
               + {{(rcsp_pkg::COM_W-rcsp_pkg::FPK_W){1'b0}}, w_qmid.fpk}
               + rcsp_pkg::ROOT_BYTES;
        // one repeat per power of two from 4 up to the recovery count
        for (int k = 2; k < rcsp_pkg::REC_W; k++) begin
            th[k] = (n3_rec >> k) != '0;
        end
        p = rcsp_pkg::REP_W'(2 + $countones(th));
        n3_rep = rcsp_pkg::rep_cap(i_red, p);
    end

    // stage 4: common times repeats, low half of recovery data product
    logic                         r_v4;
    logic [rcsp_pkg::TOT_W-1:0]   r4_cp, r4_mlo;
    logic [rcsp_pkg::BLK_W:0]     r4_a;
    logic [rcsp_pkg::REC_W-1:0]   r4_rec;
    logic [rcsp_pkg::REP_W-1:0]   r4_rep;
    logic [rcsp_pkg::INB_W-1:0]   r4_inb;
    logic [rcsp_pkg::BLK_W:0]     w_a;
    logic [rcsp_pkg::TOT_W-1:0]   w_mlo;

    assign w_a   = rcsp_pkg::RDATA_HDR + {1'b0, r3_blk};
    assign w_mlo = rcsp_pkg::TOT_W'(w_a) * rcsp_pkg::TOT_W'(r3_rec[rcsp_pkg::BLK_W-1:0]);

    // stage 5: high half product, partial sum
    logic                         r_v5;
    logic [rcsp_pkg::TOT_W-1:0]   r5_part;
    logic [rcsp_pkg::BLK_W-1:0]   r5_mhi;
    logic [rcsp_pkg::REC_W-1:0]   r5_rec;
    logic [rcsp_pkg::REP_W-1:0]   r5_rep;
    logic [rcsp_pkg::INB_W-1:0]   r5_inb;
    logic [rcsp_pkg::BLK_W-1:0]   w_mhi;

    // only the low word of the high product lands inside 64 bits
    assign w_mhi = rcsp_pkg::BLK_W'(r4_a * r4_rec[rcsp_pkg::REC_W-1:rcsp_pkg::BLK_W]);

    // stage 6: result register
    logic                         r_v6;
    logic [rcsp_pkg::TOT_W-1:0]   r6_tot;
    logic [rcsp_pkg::REC_W-1:0]   r6_rec;
    logic [rcsp_pkg::REP_W-1:0]   r6_rep;
    logic [rcsp_pkg::INB_W-1:0]   r6_inb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= w_qv;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_inb  <= n1_inb;
            r1_dq   <= i_res.dq;
            r1_fq   <= i_res.fq;
            r1_fpk  <= n1_fpk;
            r1_blk  <= i_res.side.blk;
            r2_y    <= n2_y;
            r2_mid  <= n2_mid;
            r3_rec  <= n3_rec;
            r3_com  <= n3_com;
            r3_rep  <= n3_rep;
            r3_inb  <= w_qmid.inb;
            r3_blk  <= w_qmid.blk;
            r4_cp   <= rcsp_pkg::TOT_W'(r3_com) * rcsp_pkg::TOT_W'(r3_rep);
            r4_mlo  <= w_mlo;
            r4_a    <= w_a;
            r4_rec  <= r3_rec;
            r4_rep  <= r3_rep;
            r4_inb  <= r3_inb;
            r5_part <= {{(rcsp_pkg::TOT_W-rcsp_pkg::CRE_W){1'b0}}, i_creator}
                     + r4_cp + r4_mlo;
            r5_mhi  <= w_mhi;
            r5_rec  <= r4_rec;
            r5_rep  <= r4_rep;
            r5_inb  <= r4_inb;
            r6_tot  <= r5_part + {r5_mhi, {rcsp_pkg::BLK_W{1'b0}}};
            r6_rec  <= r5_rec;
            r6_rep  <= r5_rep;
            r6_inb  <= r5_inb;
        end
    end

    assign o_valid = r_v6;
    assign o_total = r6_tot;
    assign o_inb   = r6_inb;
    assign o_rec   = r6_rec;
    assign o_rep   = r6_rep;

endmodule

// ----- src/recovery_packet_size_planner_core.sv -----
// top level of the recovery packet size planner
// pipeline from input accept to output valid: 48 divider stages, 2 count
//   stages, 4 divide-by-25 stages, 4 sum and multiply stages
// throughput: one item per cycle; the whole pipe advances together and holds
//   only while a finished result sits in the output register untaken
// reset: synchronous active low, clears all valid bits and both config
//   registers; payload registers are not reset
module recovery_packet_size_planner_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write port
    input  logic                          i_cfg_we,
    input  logic [rcsp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rcsp_pkg::CFG_W-1:0]    i_cfg_data,
    // query item
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [rcsp_pkg::FILE_W-1:0]   i_file_bytes,
    input  logic [rcsp_pkg::FOOT_W-1:0]   i_footer_bytes,
    input  logic [rcsp_pkg::BLK_W-1:0]    i_block_bytes,
    input  logic [rcsp_pkg::NAME_W-1:0]   i_name_length,
    // result item
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [rcsp_pkg::TOT_W-1:0]    o_total_bytes,
    output logic [rcsp_pkg::INB_W-1:0]    o_input_blocks,
    output logic [rcsp_pkg::REC_W-1:0]    o_recovery_blocks,
    output logic [rcsp_pkg::REP_W-1:0]    o_repeat_times
);

    // config registers, to be written by the user only while the pipe is empty; the block does not enforce it
    logic [rcsp_pkg::RED_W-1:0] r_red;
    logic [rcsp_pkg::CRE_W-1:0] r_cre;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red <= '0;
            r_cre <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rcsp_pkg::CFG_REDUNDANCY: r_red <= i_cfg_data[rcsp_pkg::RED_W-1:0];
                rcsp_pkg::CFG_CREATOR:    r_cre <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // redundancy above the limit counts as none
    logic [rcsp_pkg::RED_W-1:0] w_red;
    assign w_red = (r_red <= rcsp_pkg::RED_MAX) ? r_red : '0;

    // pipe advance: everything moves unless the result is held
    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // zero block size acts as one; a footer larger than the file leaves no data
    rcsp_pkg::t_side             w_side;
    logic [rcsp_pkg::FILE_W-1:0] w_data;
    logic [rcsp_pkg::FILE_W-1:0] w_foot_ext;

    assign w_foot_ext  = {{(rcsp_pkg::FILE_W-rcsp_pkg::FOOT_W){1'b0}}, i_footer_bytes};
    assign w_data      = (w_foot_ext <= i_file_bytes) ? (i_file_bytes - w_foot_ext) : '0;
    assign w_side.blk  = (i_block_bytes == '0) ? rcsp_pkg::BLK_W'(1) : i_block_bytes;
    assign w_side.name = i_name_length;
    assign w_side.foot = i_footer_bytes;

    // divider: data and footer by block size, one quotient bit per stage
    logic              w_dv;
    rcsp_pkg::t_divres w_dres;

    rcsp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid && w_en),
        .i_data  (w_data),
        .i_side  (w_side),
        .o_valid (w_dv),
        .o_res   (w_dres)
    );

    // counts, recovery blocks, packet sizes and the total
    rcsp_plan u_plan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_dv),
        .i_res     (w_dres),
        .i_red     (w_red),
        .i_creator (r_cre),
        .o_valid   (o_out_valid),
        .o_total   (o_total_bytes),
        .o_inb     (o_input_blocks),
        .o_rec     (o_recovery_blocks),
        .o_rep     (o_repeat_times)
    );

    // recovery count never drops to zero
    a_rec_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_recovery_blocks != '0)
        else $error("recovery block count is zero");

    // no redundancy gives exactly one recovery block
    a_rec_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && w_red == '0) |-> o_recovery_blocks == rcsp_pkg::REC_W'(1))
        else $error("zero redundancy gave more than one recovery block");

    // repeat count stays within its bounds
    a_rep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_repeat_times >= 7'd2 && o_repeat_times <= 7'd64))
        else $error("repeat count out of range");

    // input only stalls behind a held result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a held result");

endmodule
